// ===== rtl/via_pkg.sv =====
// ----------------------------------------------------------------------------
// VIA package
// Beat types, access codes and the register map of the interface adapter.
// ----------------------------------------------------------------------------
package via_pkg;

  // Access codes carried in the mode field of an input beat.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // Register map.
  localparam logic [3:0] REG_ORB   = 4'd0;
  localparam logic [3:0] REG_ORA   = 4'd1;
  localparam logic [3:0] REG_DDRB  = 4'd2;
  localparam logic [3:0] REG_DDRA  = 4'd3;
  localparam logic [3:0] REG_T1CL  = 4'd4;
  localparam logic [3:0] REG_T1CH  = 4'd5;
  localparam logic [3:0] REG_T1LL  = 4'd6;
  localparam logic [3:0] REG_T1LH  = 4'd7;
  localparam logic [3:0] REG_T2CL  = 4'd8;
  localparam logic [3:0] REG_T2CH  = 4'd9;
  localparam logic [3:0] REG_SR    = 4'd10;
  localparam logic [3:0] REG_ACR   = 4'd11;
  localparam logic [3:0] REG_PCR   = 4'd12;
  localparam logic [3:0] REG_IFR   = 4'd13;
  localparam logic [3:0] REG_IER   = 4'd14;
  localparam logic [3:0] REG_ORA_NH = 4'd15;

  // Interrupt flag bits and control bits.
  localparam logic [6:0] FLAG_T1      = 7'h40;
  localparam logic [6:0] FLAG_T2      = 7'h20;
  localparam int         ACR_T1_FREE  = 6;
  localparam int         ACR_T2_PULSE = 5;
  localparam int         IER_SET      = 7;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
  } via_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_out;
    logic [7:0] port_a_dir;
    logic [7:0] port_b_out;
    logic [7:0] port_b_dir;
    logic       irq;
    logic       pb7_timer_level;
  } via_out_t;

endpackage

// ===== rtl/via_regs.sv =====
// ----------------------------------------------------------------------------
// VIA register file and timers
// Holds all adapter state and works out the next state and the result of one
// beat (tick, read or write) in a single combinational pass.
// ----------------------------------------------------------------------------
module via_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  via_pkg::via_in_t item,
  output via_pkg::via_out_t result
);
  import via_pkg::*;

  logic [7:0]  out_latch_a, out_latch_a_next;
  logic [7:0]  out_latch_b, out_latch_b_next;
  logic [7:0]  direction_a, direction_a_next;
  logic [7:0]  direction_b, direction_b_next;
  logic [15:0] timer1_latch, timer1_latch_next;
  logic [15:0] timer1_count, timer1_count_next;
  logic        timer1_armed, timer1_armed_next;
  logic [7:0]  timer2_latch_low, timer2_latch_low_next;
  logic [15:0] timer2_count, timer2_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  aux_control, aux_control_next;
  logic [7:0]  periph_control, periph_control_next;
  logic [6:0]  int_flags, int_flags_next;
  logic [6:0]  int_enables, int_enables_next;
  logic        pb7_toggle, pb7_toggle_next;
  logic [7:0]  rd;
  logic [7:0]  port_a_in;
  logic [7:0]  port_b_in;

  assign port_a_in = (direction_a & out_latch_a) | (~direction_a & item.port_a_pins);
  assign port_b_in = (direction_b & out_latch_b) | (~direction_b & item.port_b_pins);

  always_comb begin
    out_latch_a_next      = out_latch_a;
    out_latch_b_next      = out_latch_b;
    direction_a_next      = direction_a;
    direction_b_next      = direction_b;
    timer1_latch_next     = timer1_latch;
    timer1_count_next     = timer1_count;
    timer1_armed_next     = timer1_armed;
    timer2_latch_low_next = timer2_latch_low;
    timer2_count_next     = timer2_count;
    shift_byte_next       = shift_byte;
    aux_control_next      = aux_control;
    periph_control_next   = periph_control;
    int_flags_next        = int_flags;
    int_enables_next      = int_enables;
    pb7_toggle_next       = pb7_toggle;
    rd                    = 8'h00;

    unique case (item.mode)
      MODE_TICK: begin
        // An all-ones count is the reload tick; the step from zero to all
        // ones is the underflow, which gives the period of latch plus two.
        if (timer1_count == 16'hffff) begin
          timer1_count_next = timer1_latch;
        end else if (timer1_count == 16'h0000) begin
          timer1_count_next = 16'hffff;
          if (timer1_armed) begin
            int_flags_next  = int_flags | FLAG_T1;
            pb7_toggle_next = ~pb7_toggle;
            if (!aux_control[ACR_T1_FREE]) begin
              timer1_armed_next = 1'b0;
            end
          end
        end else begin
          timer1_count_next = timer1_count - 16'd1;
        end
        if (!aux_control[ACR_T2_PULSE]) begin
          timer2_count_next = timer2_count - 16'd1;
        end
      end
      MODE_READ: begin
        unique case (item.reg_addr)
          REG_ORB:  rd = port_b_in;
          REG_ORA, REG_ORA_NH: rd = port_a_in;
          REG_DDRB: rd = direction_b;
          REG_DDRA: rd = direction_a;
          REG_T1CL: begin
            rd             = timer1_count[7:0];
            int_flags_next = int_flags & ~FLAG_T1;
          end
          REG_T1CH: rd = timer1_count[15:8];
          REG_T1LL: rd = timer1_latch[7:0];
          REG_T1LH: rd = timer1_latch[15:8];
          REG_T2CL: begin
            rd             = timer2_count[7:0];
            int_flags_next = int_flags & ~FLAG_T2;
          end
          REG_T2CH: rd = timer2_count[15:8];
          REG_SR:   rd = shift_byte;
          REG_ACR:  rd = aux_control;
          REG_PCR:  rd = periph_control;
          REG_IFR:  rd = {|(int_flags & int_enables), int_flags};
          REG_IER:  rd = {1'b1, int_enables};
          default:  rd = 8'h00;
        endcase
      end
      MODE_WRITE: begin
        unique case (item.reg_addr)
          REG_ORB:  out_latch_b_next = item.write_data;
          REG_ORA, REG_ORA_NH: out_latch_a_next = item.write_data;
          REG_DDRB: direction_b_next = item.write_data;
          REG_DDRA: direction_a_next = item.write_data;
          REG_T1CL, REG_T1LL: timer1_latch_next[7:0] = item.write_data;
          REG_T1CH: begin
            timer1_latch_next = {item.write_data, timer1_latch[7:0]};
            timer1_count_next = {item.write_data, timer1_latch[7:0]};
            timer1_armed_next = 1'b1;
            pb7_toggle_next   = 1'b0;
            int_flags_next    = int_flags & ~FLAG_T1;
          end
          REG_T1LH: begin
            timer1_latch_next[15:8] = item.write_data;
            int_flags_next          = int_flags & ~FLAG_T1;
          end
          REG_T2CL: timer2_latch_low_next = item.write_data;
          REG_T2CH: begin
            timer2_count_next = {item.write_data, timer2_latch_low};
            int_flags_next    = int_flags & ~FLAG_T2;
          end
          REG_SR:   shift_byte_next     = item.write_data;
          REG_ACR:  aux_control_next    = item.write_data;
          REG_PCR:  periph_control_next = item.write_data;
          REG_IFR:  int_flags_next      = int_flags & ~item.write_data[6:0];
          REG_IER: begin
            if (item.write_data[IER_SET]) begin
              int_enables_next = int_enables | item.write_data[6:0];
            end else begin
              int_enables_next = int_enables & ~item.write_data[6:0];
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_latch_a      <= 8'h00;
      out_latch_b      <= 8'h00;
      direction_a      <= 8'h00;
      direction_b      <= 8'h00;
      timer1_latch     <= 16'h0000;
      timer1_count     <= 16'hffff;
      timer1_armed     <= 1'b0;
      timer2_latch_low <= 8'h00;
      timer2_count     <= 16'hffff;
      shift_byte       <= 8'h00;
      aux_control      <= 8'h00;
      periph_control   <= 8'h00;
      int_flags        <= 7'h00;
      int_enables      <= 7'h00;
      pb7_toggle       <= 1'b0;
    end else if (step) begin
      out_latch_a      <= out_latch_a_next;
      out_latch_b      <= out_latch_b_next;
      direction_a      <= direction_a_next;
      direction_b      <= direction_b_next;
      timer1_latch     <= timer1_latch_next;
      timer1_count     <= timer1_count_next;
      timer1_armed     <= timer1_armed_next;
      timer2_latch_low <= timer2_latch_low_next;
      timer2_count     <= timer2_count_next;
      shift_byte       <= shift_byte_next;
      aux_control      <= aux_control_next;
      periph_control   <= periph_control_next;
      int_flags        <= int_flags_next;
      int_enables      <= int_enables_next;
      pb7_toggle       <= pb7_toggle_next;
    end
  end

  // The result reflects the state as it stands after this beat.
  always_comb begin
    result.read_data       = rd;
    result.port_a_out      = out_latch_a_next;
    result.port_a_dir      = direction_a_next;
    result.port_b_out      = out_latch_b_next;
    result.port_b_dir      = direction_b_next;
    result.irq             = |(int_flags_next & int_enables_next);
    result.pb7_timer_level = pb7_toggle_next;
  end

endmodule

// ===== rtl/versatile_interface_adapter.sv =====
// ----------------------------------------------------------------------------
// Versatile interface adapter
// Two 8-bit ports, two 16-bit timers and an interrupt controller behind a
// sixteen-register map, driven by a stream of tick, read and write beats.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one beat per item:
//   a clock tick for the timers, a register read or a register write. The
//   output channel (out_valid, out_ready, out_data) returns exactly one beat
//   per input beat, in order, with the read byte (zero for ticks and writes),
//   the port latches and directions, the interrupt request and the PB7 level.
//   A beat accepted at one edge has its result on the output register from the
//   next cycle on. Throughput is one beat per cycle while the receiver keeps
//   up; all state updates happen in one combinational pass into the registers.
//   A single output register parts the channels: a new beat is taken whenever
//   the output register is empty or being drained in the same cycle, so a
//   stalled receiver holds the input off only while a result is waiting.
//   Reset clears the output register and puts all registers at their
//   power-on values (both timer counts all ones, everything else zero).
// ----------------------------------------------------------------------------
module versatile_interface_adapter (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  via_pkg::via_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output via_pkg::via_out_t out_data
);
  import via_pkg::*;

  logic     accept;
  via_out_t result;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  via_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .item   (in_data),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

// ===== rtl/via_chk.sv =====
// ----------------------------------------------------------------------------
// VIA port checker
// Watches the adapter's ports for handshake and result ordering slips.
// ----------------------------------------------------------------------------
module via_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input via_pkg::via_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input via_pkg::via_out_t out_data
);
  import via_pkg::*;

  // A waiting result is held until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Every accepted beat shows its result in the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // An empty output register never holds the input off.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // Only reads return data.
  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode != MODE_READ |=> out_data.read_data == 8'h00)
    else $error("nonzero read data on a tick or write");

  // Disabling every interrupt source drops the request at once.
  a_irq_off: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode == MODE_WRITE && in_data.reg_addr == REG_IER
      && in_data.write_data == 8'h7f |=> !out_data.irq)
    else $error("interrupt request after all sources disabled");

endmodule

bind versatile_interface_adapter via_chk u_via_chk (.*);

// ===== sim/versatile_interface_adapter_tb.sv =====
// ----------------------------------------------------------------------------
// Interface adapter testbench
// Sends tick, read and write beats into the adapter and checks every result
// beat against an in-bench model of the ports, timers and interrupt logic.
// A short directed table comes first, then random timer and register traffic.
// ----------------------------------------------------------------------------
module versatile_interface_adapter_tb;
  import via_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEMS           = 1800;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 4;

  typedef struct {
    via_in_t  stim;
    bit       typed;
    via_out_t want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  via_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  via_out_t out_data;

  // Model state of the adapter.
  logic [7:0]  ora, orb, ddra, ddrb, shift_q, acr, pcr, t2_lo;
  logic [15:0] t1_latch, t1_count, t2_count;
  logic        t1_armed, pb7;
  logic [6:0]  ifr, ier;

  via_out_t pending_results [$];
  dir_row_t directed [$];
  int mismatches  = 0;
  int beats_sent  = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;

  always #2 clk = ~clk;

  versatile_interface_adapter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic via_out_t next_result(via_in_t b);
    via_out_t r;
    logic [7:0] rd;
    rd = 8'h00;
    case (b.mode)
      MODE_TICK: begin
        if (t1_count == 16'hffff) begin
          t1_count = t1_latch;
        end else if (t1_count == 16'h0000) begin
          // Underflow: the count wraps to all ones and reloads on the next tick.
          t1_count = 16'hffff;
          if (t1_armed) begin
            ifr = ifr | FLAG_T1;
            pb7 = ~pb7;
            if (!acr[ACR_T1_FREE]) t1_armed = 1'b0;
          end
        end else begin
          t1_count = t1_count - 16'd1;
        end
        if (!acr[ACR_T2_PULSE]) t2_count = t2_count - 16'd1;
      end
      MODE_READ: begin
        case (b.reg_addr)
          REG_ORB: rd = (ddrb & orb) | (~ddrb & b.port_b_pins);
          REG_ORA, REG_ORA_NH: rd = (ddra & ora) | (~ddra & b.port_a_pins);
          REG_DDRB: rd = ddrb;
          REG_DDRA: rd = ddra;
          REG_T1CL: begin
            ifr = ifr & ~FLAG_T1;
            rd  = t1_count[7:0];
          end
          REG_T1CH: rd = t1_count[15:8];
          REG_T1LL: rd = t1_latch[7:0];
          REG_T1LH: rd = t1_latch[15:8];
          REG_T2CL: begin
            ifr = ifr & ~FLAG_T2;
            rd  = t2_count[7:0];
          end
          REG_T2CH: rd = t2_count[15:8];
          REG_SR:   rd = shift_q;
          REG_ACR:  rd = acr;
          REG_PCR:  rd = pcr;
          REG_IFR:  rd = {|(ifr & ier), ifr};
          default:  rd = {1'b1, ier};
        endcase
      end
      MODE_WRITE: begin
        case (b.reg_addr)
          REG_ORB: orb = b.write_data;
          REG_ORA, REG_ORA_NH: ora = b.write_data;
          REG_DDRB: ddrb = b.write_data;
          REG_DDRA: ddra = b.write_data;
          REG_T1CL, REG_T1LL: t1_latch[7:0] = b.write_data;
          REG_T1CH: begin
            t1_latch[15:8] = b.write_data;
            t1_count = t1_latch;
            t1_armed = 1'b1;
            pb7 = 1'b0;
            ifr = ifr & ~FLAG_T1;
          end
          REG_T1LH: begin
            t1_latch[15:8] = b.write_data;
            ifr = ifr & ~FLAG_T1;
          end
          REG_T2CL: t2_lo = b.write_data;
          REG_T2CH: begin
            t2_count = {b.write_data, t2_lo};
            ifr = ifr & ~FLAG_T2;
          end
          REG_SR:  shift_q = b.write_data;
          REG_ACR: acr = b.write_data;
          REG_PCR: pcr = b.write_data;
          REG_IFR: ifr = ifr & ~b.write_data[6:0];
          default: begin
            if (b.write_data[IER_SET]) ier = ier | b.write_data[6:0];
            else ier = ier & ~b.write_data[6:0];
          end
        endcase
      end
      default: ;
    endcase
    r.read_data       = rd;
    r.port_a_out      = ora;
    r.port_a_dir      = ddra;
    r.port_b_out      = orb;
    r.port_b_dir      = ddrb;
    r.irq             = |(ifr & ier);
    r.pb7_timer_level = pb7;
    return r;
  endfunction

  function automatic via_in_t bus_beat(logic [1:0] m, logic [3:0] a, logic [7:0] d);
    return {m, a, d, 8'($urandom), 8'($urandom)};
  endfunction

  // Timer bytes are kept small most of the time so that underflows happen often.
  function automatic logic [7:0] short_lo();
    return ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(6));
  endfunction

  function automatic logic [7:0] short_hi();
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send(via_in_t b, bit typed, via_out_t want);
    via_out_t predicted;
    if (!calm)
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = next_result(b);
    pending_results.push_back(typed ? want : predicted);
    beats_sent++;
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    via_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, out_data.read_data);
        check_field("port_a_out", want.port_a_out, out_data.port_a_out);
        check_field("port_a_dir", want.port_a_dir, out_data.port_a_dir);
        check_field("port_b_out", want.port_b_out, out_data.port_b_out);
        check_field("port_b_dir", want.port_b_dir, out_data.port_b_dir);
        check_field("irq", 8'(want.irq), 8'(out_data.irq));
        check_field("pb7_timer_level", 8'(want.pb7_timer_level),
                    8'(out_data.pb7_timer_level));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("versatile_interface_adapter_tb failed");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    logic [3:0] a;
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;

    ora = '0; orb = '0; ddra = '0; ddrb = '0;
    shift_q = '0; acr = '0; pcr = '0; t2_lo = '0;
    t1_latch = '0; t1_count = 16'hffff; t2_count = 16'hffff;
    t1_armed = 1'b0; pb7 = 1'b0; ifr = '0; ier = '0;

    // Typed rows carry results that follow directly from the reset values.
    directed = '{
      '{{MODE_READ,  REG_IER,    8'h00, 8'h00, 8'h00}, 1'b1, {8'h80, 34'h0}},
      '{{MODE_READ,  REG_IFR,    8'h00, 8'hff, 8'hff}, 1'b1, {8'h00, 34'h0}},
      '{{MODE_READ,  REG_T1CH,   8'h00, 8'h00, 8'h00}, 1'b1, {8'hff, 34'h0}},
      '{{MODE_READ,  REG_T2CH,   8'h00, 8'h00, 8'h00}, 1'b1, {8'hff, 34'h0}},
      '{{MODE_READ,  REG_ORB,    8'h00, 8'h00, 8'ha5}, 1'b1, {8'ha5, 34'h0}},
      '{{MODE_WRITE, REG_DDRA,   8'hff, 8'h00, 8'h00}, 1'b1,
        {8'h00, 8'h00, 8'hff, 16'h0, 2'b00}},
      '{{MODE_WRITE, REG_ORA,    8'h5a, 8'h00, 8'h00}, 1'b1,
        {8'h00, 8'h5a, 8'hff, 16'h0, 2'b00}},
      '{{MODE_READ,  REG_ORA_NH, 8'h00, 8'h00, 8'h00}, 1'b1,
        {8'h5a, 8'h5a, 8'hff, 16'h0, 2'b00}},
      '{{MODE_WRITE, REG_DDRB,   8'h0f, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_WRITE, REG_ORB,    8'hff, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_READ,  REG_ORB,    8'h00, 8'hff, 8'h30}, 1'b0, '0},
      '{{MODE_WRITE, REG_T1LL,   8'h02, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_WRITE, REG_IER,    8'hff, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_WRITE, REG_T1CH,   8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_TICK,  REG_ORB,    8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_TICK,  REG_ORB,    8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_TICK,  REG_ORB,    8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_READ,  REG_IFR,    8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_READ,  REG_T1CL,   8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_WRITE, REG_ACR,    8'h60, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_WRITE, REG_T2CL,   8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_WRITE, REG_T2CH,   8'hff, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_WRITE, REG_IFR,    8'h7f, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_WRITE, REG_IER,    8'h7f, 8'h00, 8'h00}, 1'b0, '0},
      '{{MODE_UNUSED, REG_ORA_NH, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{{MODE_WRITE, REG_T1LH,   8'hff, 8'h00, 8'h00}, 1'b0, '0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send(directed[i].stim, directed[i].typed, directed[i].want);

    while (beats_sent < ITEMS) begin
      case ($urandom_range(5))
        0: begin
          // Program timer 1 with a short period and let it run.
          send(bus_beat(MODE_WRITE, REG_T1LL, short_lo()), 1'b0, '0);
          if ($urandom_range(1))
            send(bus_beat(MODE_WRITE, REG_ACR, 8'($urandom)), 1'b0, '0);
          if ($urandom_range(1))
            send(bus_beat(MODE_WRITE, REG_IER, {1'b1, 7'($urandom)}), 1'b0, '0);
          send(bus_beat(MODE_WRITE, REG_T1CH, short_hi()), 1'b0, '0);
          repeat ($urandom_range(24)) send(bus_beat(MODE_TICK, 4'($urandom), 8'($urandom)),
                                           1'b0, '0);
          send(bus_beat(MODE_READ, REG_IFR, 8'($urandom)), 1'b0, '0);
          if ($urandom_range(1))
            send(bus_beat(MODE_READ, REG_T1CL, 8'($urandom)), 1'b0, '0);
        end
        1: begin
          send(bus_beat(MODE_WRITE, REG_T2CL, short_lo()), 1'b0, '0);
          send(bus_beat(MODE_WRITE, REG_T2CH, short_hi()), 1'b0, '0);
          repeat ($urandom_range(12)) send(bus_beat(MODE_TICK, 4'($urandom), 8'($urandom)),
                                           1'b0, '0);
          send(bus_beat(MODE_READ, $urandom_range(1) ? REG_T2CL : REG_T2CH, 8'($urandom)),
               1'b0, '0);
        end
        2: begin
          a = 4'($urandom);
          if (a == REG_T1CH || a == REG_T1LH || a == REG_T2CH)
            send(bus_beat(MODE_WRITE, a, short_hi()), 1'b0, '0);
          else
            send(bus_beat(MODE_WRITE, a, 8'($urandom)), 1'b0, '0);
        end
        3: send(bus_beat(MODE_READ, 4'($urandom), 8'($urandom)), 1'b0, '0);
        4: repeat ($urandom_range(1, 16))
             send(bus_beat(MODE_TICK, 4'($urandom), 8'($urandom)), 1'b0, '0);
        default: begin
          send(bus_beat(MODE_UNUSED, 4'($urandom), 8'($urandom)), 1'b0, '0);
          send(bus_beat(MODE_WRITE, REG_IER, 8'($urandom)), 1'b0, '0);
        end
      endcase

      // Long receiver hold-off while beats keep coming, inside a stretch
      // with no idling on either side.
      if (!held && beats_sent >= 500) begin
        held = 1'b1;
        calm = 1'b1;
        hold_off_req = 1'b1;
      end
      if (calm && beats_sent >= 900) calm = 1'b0;
      if (!paused && beats_sent >= 1300) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("versatile_interface_adapter_tb passed");
    else
      $display("versatile_interface_adapter_tb failed");
    $finish;
  end

endmodule
